### rtl/nwom_pkg.sv
// Shared types, constants and calendar helper functions for the nth-weekday unit.
`default_nettype none

package nwom_pkg;

  // Request fields as they arrive on the input channel
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [2:0]  weekday;
    logic [2:0]  occurrence;
    logic        from_end;
  } nwom_in_t;

  // Result fields as they leave on the output channel
  typedef struct packed {
    logic [4:0] day_of_month;
    logic       found;
  } nwom_out_t;

  // Shifted year width: 14-bit year plus the 400-year offset
  localparam int unsigned YEAR_W   = 15;
  localparam int unsigned SUM_W    = 15;
  localparam int unsigned PROD100_W = 28;
  localparam int unsigned PROD7_W  = 30;

  localparam int unsigned YEAR_OFFSET = 400;
  localparam int unsigned CENTURY     = 100;

  // y/100 = (y * 5243) >> 19, exact for y below 2^15
  localparam int unsigned RECIP100 = 5243;
  localparam int unsigned SHIFT100 = 19;
  // s/7 = (s * 18725) >> 17, exact for s below 2^15
  localparam int unsigned RECIP7   = 18725;
  localparam int unsigned SHIFT7   = 17;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_MAR = 4'd3;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // Entry 0 is a leap-year February, then January through December
  localparam logic [4:0] MONTH_DAYS [0:12] = '{
    5'd29, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Month part of the weekday sum: 1 + 2m + 3(m+1)/5, with January and
  // February taken as months 13 and 14
  function automatic logic [5:0] month_term(input logic [3:0] month);
    logic [5:0] term;
    case (month)
      4'd1:    term = 6'd35;
      4'd2:    term = 6'd38;
      4'd3:    term = 6'd9;
      4'd4:    term = 6'd12;
      4'd5:    term = 6'd14;
      4'd6:    term = 6'd17;
      4'd7:    term = 6'd19;
      4'd8:    term = 6'd22;
      4'd9:    term = 6'd25;
      4'd10:   term = 6'd27;
      4'd11:   term = 6'd30;
      4'd12:   term = 6'd32;
      default: term = 6'd0;
    endcase
    return term;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    if (month == MONTH_FEB && leap) begin
      len = MONTH_DAYS[0];
    end else if (month >= MONTH_JAN && month <= MONTH_DEC) begin
      len = MONTH_DAYS[month];
    end else begin
      len = MONTH_DAYS[MONTH_JAN];
    end
    return len;
  endfunction

  // Reduce a value below 14 modulo 7
  function automatic logic [2:0] mod7_small(input logic [3:0] v);
    logic [3:0] r;
    r = (v >= 4'd7) ? (v - 4'd7) : v;
    return r[2:0];
  endfunction

  // Partial results handed from the date-sum stages to the locate stages
  typedef struct packed {
    logic [SUM_W-1:0] sum;   // weekday sum before mod 7
    logic [4:0]       len;   // days in month
    logic [2:0]       lm;    // (len - 1) mod 7
    logic [2:0]       t;     // wanted weekday, 0 Monday
    logic [2:0]       occ;
    logic             back;
    logic             ok;    // request fields in range
  } nwom_sum_t;

endpackage

`default_nettype wire

### rtl/nwom_year.sv
// Two pipeline stages that form the day-of-week sum and the month length.
`default_nettype none

module nwom_year import nwom_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_vld,
  input  nwom_in_t       in_q,
  output logic           sum_vld,
  output nwom_sum_t      sum_q
);

  // Stage 1 registers
  logic                  v1_r, v1_nxt;
  logic [YEAR_W-1:0]     y1_r, y1_nxt;
  logic [PROD100_W-1:0]  prod1_r, prod1_nxt;
  logic [5:0]            mterm1_r, mterm1_nxt;
  logic [3:0]            month1_r;
  logic [2:0]            t1_r, t1_nxt;
  logic [2:0]            occ1_r;
  logic                  back1_r;
  logic                  ok1_r, ok1_nxt;

  // Stage 2 registers
  logic                  v2_r;
  nwom_sum_t             s2_r, s2_nxt;

  logic [8:0]            q100;
  logic [YEAR_W-1:0]     r100;
  logic                  div4, div100, div400, leap;

  // Stage 1: shift the year, start y/100 by reciprocal multiply
  always_comb begin
    y1_nxt     = YEAR_W'(in_q.year) + YEAR_W'(YEAR_OFFSET)
               - YEAR_W'(in_q.month < MONTH_MAR);
    prod1_nxt  = PROD100_W'(y1_nxt) * PROD100_W'(RECIP100);
    mterm1_nxt = month_term(in_q.month);
    t1_nxt     = in_q.weekday - 3'd1;
    ok1_nxt    = (in_q.month inside {[MONTH_JAN:MONTH_DEC]}) && (in_q.weekday != 3'd0)
               && (in_q.occurrence inside {[3'd1:3'd5]});
    v1_nxt     = in_vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
    end
    y1_r     <= y1_nxt;
    prod1_r  <= prod1_nxt;
    mterm1_r <= mterm1_nxt;
    month1_r <= in_q.month;
    t1_r     <= t1_nxt;
    occ1_r   <= in_q.occurrence;
    back1_r  <= in_q.from_end;
    ok1_r    <= ok1_nxt;
  end

  // Stage 2: finish the sum; leap test only matters for February, where
  // the shifted year is one below the real year
  always_comb begin
    q100   = prod1_r[SHIFT100 +: 9];
    r100   = y1_r - YEAR_W'(YEAR_W'(q100) * YEAR_W'(CENTURY));
    div4   = (y1_r[1:0] == 2'b11);
    div100 = (r100 == YEAR_W'(CENTURY - 1));
    div400 = div100 && (q100[1:0] == 2'b11);
    leap   = (div4 && !div100) || div400;

    s2_nxt.sum  = SUM_W'(mterm1_r) + SUM_W'(y1_r) + SUM_W'(y1_r >> 2)
                - SUM_W'(q100) + SUM_W'(q100 >> 2);
    s2_nxt.len  = month_len(month1_r, leap);
    s2_nxt.lm   = (s2_nxt.len == 5'd28) ? 3'd6 : 3'(s2_nxt.len - 5'd29);
    s2_nxt.t    = t1_r;
    s2_nxt.occ  = occ1_r;
    s2_nxt.back = back1_r;
    s2_nxt.ok   = ok1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    s2_r <= s2_nxt;
  end

  assign sum_vld = v2_r;
  assign sum_q   = s2_r;

endmodule

`default_nettype wire

### rtl/nwom_locate.sv
// Two pipeline stages that reduce the sum mod 7 and place the wanted occurrence.
`default_nettype none

module nwom_locate import nwom_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      sum_vld,
  input  nwom_sum_t      sum_q,
  output logic           out_vld,
  output nwom_out_t      out_q
);

  logic                  v3_r;
  logic [PROD7_W-1:0]    prod3_r, prod3_nxt;
  nwom_sum_t             s3_r;

  logic                  v4_r;
  nwom_out_t             res4_r, res4_nxt;

  logic [12:0]           q7;
  logic [2:0]            w1, off_f, wl, off_b, occm1;
  logic [5:0]            k7, day_f, day_b, last;
  logic                  found_f, found_b, found;
  logic [5:0]            day;

  // Stage 3: quotient of the sum by 7 via reciprocal multiply
  assign prod3_nxt = PROD7_W'(sum_q.sum) * PROD7_W'(RECIP7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= sum_vld;
    end
    prod3_r <= prod3_nxt;
    s3_r    <= sum_q;
  end

  // Stage 4: remainder is below 7, so its low 3 bits suffice; s - 7q is
  // s + q modulo 8
  always_comb begin
    q7    = prod3_r[SHIFT7 +: 13];
    w1    = s3_r.sum[2:0] + q7[2:0];
    occm1 = s3_r.occ - 3'd1;
    k7    = {occm1, 3'b000} - 6'(occm1);

    // Count forward from day 1
    off_f   = mod7_small(4'(s3_r.t) + 4'd7 - 4'(w1));
    day_f   = 6'(off_f) + 6'd1 + k7;
    found_f = (day_f <= 6'(s3_r.len));

    // Count back from the last day
    wl      = mod7_small(4'(w1) + 4'(s3_r.lm));
    off_b   = mod7_small(4'(wl) + 4'd7 - 4'(s3_r.t));
    last    = 6'(s3_r.len) - 6'(off_b);
    found_b = (last > k7);
    day_b   = last - k7;

    found = s3_r.ok && (s3_r.back ? found_b : found_f);
    day   = s3_r.back ? day_b : day_f;

    res4_nxt.found        = found;
    res4_nxt.day_of_month = found ? day[4:0] : 5'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    res4_r <= res4_nxt;
  end

  assign out_vld = v4_r;
  assign out_q   = res4_r;

endmodule

`default_nettype wire

### rtl/nth_weekday_of_month_unit.sv
// Top level of the nth-weekday-of-month unit: input register and result pipeline.
//
//   channel   ports                     handshake
//   --------  ------------------------  --------------------------------------
//   request   start, busy, in_req       taken at a clock edge with start & !busy
//   result    out_valid, out_res        one-cycle strobe, receiver cannot stall
//
// Every request yields exactly one result. busy stays low: a new request is
// taken every cycle, and up to five are in flight through the input register,
// two date-sum stages and two locate stages.
// The depth is set by the two reciprocal multiplies (by 1/100 and by 1/7),
// each followed by its own register.
// Reset (rst_n low at a clock edge) drops every request in flight; no result
// strobes until new requests arrive. Nothing ever stalls the pipeline.
`default_nettype none

module nth_weekday_of_month_unit import nwom_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  nwom_in_t       in_req,
  output logic           out_valid,
  output nwom_out_t      out_res
);

  logic        v0_r, v0_nxt;
  nwom_in_t    req0_r;

  logic        sum_vld;
  nwom_sum_t   sum_q;

  // The pipeline never backs up, so never refuse a request
  assign busy   = 1'b0;
  assign v0_nxt = start && !busy;

  // Hold the request in the input register; advance it every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
    end
    req0_r <= in_req;
  end

  // Shifted year, y/100 and the weekday sum; month length with leap rule
  nwom_year u_year (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (v0_r),
    .in_q    (req0_r),
    .sum_vld (sum_vld),
    .sum_q   (sum_q)
  );

  // Weekday of day 1, then the requested occurrence in either direction
  nwom_locate u_locate (
    .clk     (clk),
    .rst_n   (rst_n),
    .sum_vld (sum_vld),
    .sum_q   (sum_q),
    .out_vld (out_valid),
    .out_q   (out_res)
  );

endmodule

`default_nettype wire
